// ===== design/shape_pair_overlap_test_assert.svh =====
// ----------------------------------------------------------------------------
// shape pair overlap test assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SHAPE_PAIR_OVERLAP_TEST_ASSERT_SVH
`define SHAPE_PAIR_OVERLAP_TEST_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define SPOT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spot assertion failed: same-cycle implication");
// next-cycle implication, disabled in reset
`define SPOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spot assertion failed: next-cycle implication");
`else
`define SPOT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SPOT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/spot_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spot_pkg
// shared constants for the shape pair overlap test
// ----------------------------------------------------------------------------
package spot_pkg;

    // default field widths
    localparam int COORD_BITS_DEF = 20;
    localparam int SIZE_BITS_DEF  = 16;

    // shape kind codes
    localparam logic KIND_CIRCLE = 1'b0;
    localparam logic KIND_BOX    = 1'b1;

endpackage

// ===== design/shape_pair_overlap_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_pair_overlap_test
// overlap test of a circle or axis-aligned box against a circle or box
// ----------------------------------------------------------------------------
// usage
//   a request is taken at a rising edge with start high and busy low; busy
//   is tied low, so a new shape pair may be presented every cycle
//   each shape: kind (0 circle, 1 box), center x/y (signed, 4 fraction bits),
//   size_one (radius or box width) and size_two (box height)
//   one result per request: overlap, marked by done for exactly one cycle
//   done is staged through the select, squares and compare registers
//   throughput: one request per cycle; each of the four register stages
//   (input, distance/select, squares, compare) advances every cycle, so
//   requests walk through in lock step
//   the receiver cannot stall: results leave in request order, one cycle each
//   reset (rst_n low, asynchronous) drops every request in flight and
//   clears done; payload registers keep whatever they held
//   circle-circle is strict, box-box and circle-box are inclusive; squares
//   are compared exactly, and halves are avoided by doubling distances
// ----------------------------------------------------------------------------
`include "shape_pair_overlap_test_assert.svh"

module shape_pair_overlap_test #(
    parameter int COORD_BITS = spot_pkg::COORD_BITS_DEF,
    parameter int SIZE_BITS  = spot_pkg::SIZE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         a_kind,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic        [SIZE_BITS-1:0]  a_size_one,
    input  logic        [SIZE_BITS-1:0]  a_size_two,
    input  logic                         b_kind,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic        [SIZE_BITS-1:0]  b_size_one,
    input  logic        [SIZE_BITS-1:0]  b_size_two,
    output logic                         done,
    output logic                         overlap
);

    // working width for doubled distances and size sums
    localparam int WW = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
    // square operands never exceed twice a size
    localparam int OPW = SIZE_BITS + 1;
    localparam int SQW = 2 * OPW;
    localparam int SUMW = SQW + 1;

    // stage one result: either settled by compares or left to the squares
    typedef struct packed {
        logic           settled;
        logic           hit;
        logic           strict;
        logic [OPW-1:0] p;
        logic [OPW-1:0] q;
        logic [OPW-1:0] c;
    } sel_t;

    // input register
    logic                         vin_reg;
    logic                         a_kind_reg;
    logic signed [COORD_BITS-1:0] a_x_reg;
    logic signed [COORD_BITS-1:0] a_y_reg;
    logic        [SIZE_BITS-1:0]  a_one_reg;
    logic        [SIZE_BITS-1:0]  a_two_reg;
    logic                         b_kind_reg;
    logic signed [COORD_BITS-1:0] b_x_reg;
    logic signed [COORD_BITS-1:0] b_y_reg;
    logic        [SIZE_BITS-1:0]  b_one_reg;
    logic        [SIZE_BITS-1:0]  b_two_reg;

    // stage one
    logic signed [COORD_BITS:0]   diff_x;
    logic signed [COORD_BITS:0]   diff_y;
    logic        [COORD_BITS-1:0] dx;
    logic        [COORD_BITS-1:0] dy;
    logic        [WW-1:0]         dx_w;
    logic        [WW-1:0]         dy_w;
    logic        [WW-1:0]         d_dbl;
    logic        [WW-1:0]         e_dbl;
    logic        [WW-1:0]         rad_sum;
    logic        [WW-1:0]         w_sum;
    logic        [WW-1:0]         h_sum;
    logic        [WW-1:0]         cb_r2;
    logic        [WW-1:0]         cb_w;
    logic        [WW-1:0]         cb_h;
    sel_t                         sel_next;
    sel_t                         sel_reg;
    logic                         vsel_reg;

    // stage two
    logic [SQW-1:0] sq_p_next;
    logic [SQW-1:0] sq_q_next;
    logic [SQW-1:0] sq_c_next;
    logic [SQW-1:0] sq_p_reg;
    logic [SQW-1:0] sq_q_reg;
    logic [SQW-1:0] sq_c_reg;
    logic           vsq_reg;
    logic           settled_reg;
    logic           hit_reg;
    logic           strict_reg;

    // stage three
    logic [SUMW-1:0] sq_sum;
    logic            overlap_next;
    logic            done_reg;
    logic            overlap_reg;

    logic accept;

    // every stage moves each cycle, so no request is ever refused
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vin_reg <= 1'b0;
        end
        else
        begin
            vin_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg <= a_kind;
            a_x_reg    <= a_x;
            a_y_reg    <= a_y;
            a_one_reg  <= a_size_one;
            a_two_reg  <= a_size_two;
            b_kind_reg <= b_kind;
            b_x_reg    <= b_x;
            b_y_reg    <= b_y;
            b_one_reg  <= b_size_one;
            b_two_reg  <= b_size_two;
        end
    end

    // ------------------------------------------------------------------
    // stage one: center distances, extent sums and early decisions
    // ------------------------------------------------------------------
    assign diff_x = (COORD_BITS+1)'(a_x_reg) - (COORD_BITS+1)'(b_x_reg);
    assign diff_y = (COORD_BITS+1)'(a_y_reg) - (COORD_BITS+1)'(b_y_reg);
    assign dx     = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
    assign dy     = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
    assign dx_w   = WW'(dx);
    assign dy_w   = WW'(dy);
    // doubled distances stand in for the half extents of a box
    assign d_dbl  = dx_w << 1;
    assign e_dbl  = dy_w << 1;

    assign rad_sum = WW'(a_one_reg) + WW'(b_one_reg);
    assign w_sum   = WW'(a_one_reg) + WW'(b_one_reg);
    assign h_sum   = WW'(a_two_reg) + WW'(b_two_reg);

    // circle against box: pick the circle's doubled radius and the box's extents
    assign cb_r2 = (a_kind_reg == spot_pkg::KIND_CIRCLE) ? (WW'(a_one_reg) << 1)
                                                         : (WW'(b_one_reg) << 1);
    assign cb_w  = (a_kind_reg == spot_pkg::KIND_CIRCLE) ? WW'(b_one_reg) : WW'(a_one_reg);
    assign cb_h  = (a_kind_reg == spot_pkg::KIND_CIRCLE) ? WW'(b_two_reg) : WW'(a_two_reg);

    always_comb
    begin
        sel_next = '0;
        case ({a_kind_reg, b_kind_reg})
            {spot_pkg::KIND_CIRCLE, spot_pkg::KIND_CIRCLE}:
            begin
                // outside the bounding square of the radius sum: no hit
                if ((dx_w >= rad_sum) || (dy_w >= rad_sum))
                begin
                    sel_next.settled = 1'b1;
                    sel_next.hit     = 1'b0;
                end
                sel_next.strict = 1'b1;
                sel_next.p      = dx_w[OPW-1:0];
                sel_next.q      = dy_w[OPW-1:0];
                sel_next.c      = rad_sum[OPW-1:0];
            end
            {spot_pkg::KIND_BOX, spot_pkg::KIND_BOX}:
            begin
                sel_next.settled = 1'b1;
                sel_next.hit     = (d_dbl <= w_sum) && (e_dbl <= h_sum);
            end
            default:
            begin
                if ((d_dbl > cb_w + cb_r2) || (e_dbl > cb_h + cb_r2))
                begin
                    // beyond the box grown by the radius
                    sel_next.settled = 1'b1;
                    sel_next.hit     = 1'b0;
                end
                else if ((d_dbl <= cb_w) || (e_dbl <= cb_h))
                begin
                    // center within an edge band of the grown box
                    sel_next.settled = 1'b1;
                    sel_next.hit     = 1'b1;
                end
                // corner region: distance to the box corner against the radius
                sel_next.p = OPW'(d_dbl - cb_w);
                sel_next.q = OPW'(e_dbl - cb_h);
                sel_next.c = cb_r2[OPW-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vsel_reg <= 1'b0;
        end
        else
        begin
            vsel_reg <= vin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
    end

    // ------------------------------------------------------------------
    // stage two: squares
    // ------------------------------------------------------------------
    assign sq_p_next = SQW'(sel_reg.p) * SQW'(sel_reg.p);
    assign sq_q_next = SQW'(sel_reg.q) * SQW'(sel_reg.q);
    assign sq_c_next = SQW'(sel_reg.c) * SQW'(sel_reg.c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vsq_reg <= 1'b0;
        end
        else
        begin
            vsq_reg <= vsel_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_p_reg    <= sq_p_next;
        sq_q_reg    <= sq_q_next;
        sq_c_reg    <= sq_c_next;
        settled_reg <= sel_reg.settled;
        hit_reg     <= sel_reg.hit;
        strict_reg  <= sel_reg.strict;
    end

    // ------------------------------------------------------------------
    // stage three: sum of squares against the squared reach
    // ------------------------------------------------------------------
    assign sq_sum = SUMW'(sq_p_reg) + SUMW'(sq_q_reg);

    always_comb
    begin
        if (settled_reg)
        begin
            overlap_next = hit_reg;
        end
        else if (strict_reg)
        begin
            overlap_next = (sq_sum < SUMW'(sq_c_reg));
        end
        else
        begin
            overlap_next = (sq_sum <= SUMW'(sq_c_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vsq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        overlap_reg <= overlap_next;
    end

    assign done    = done_reg;
    assign overlap = overlap_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SPOT_ASSERT_NEXT(a_fixed_latency, clk, rst_n, accept, ##3 done)
    `SPOT_ASSERT_IMPL(a_no_spurious_done, clk, rst_n, done, $past(accept, 4))
    `SPOT_ASSERT_IMPL(a_operands_in_reach, clk, rst_n,
        vsel_reg && !sel_reg.settled,
        (sel_reg.p <= sel_reg.c) && (sel_reg.q <= sel_reg.c))
    `SPOT_ASSERT_NEXT(a_settled_passes, clk, rst_n,
        vsq_reg && settled_reg, overlap == $past(hit_reg))

endmodule
